// ===== sv/hmcm_pkg.sv =====
// hmcm_pkg: shared types and constants for the heat-map min/max colormap block
// used by hmcm_ctrl, hmcm_dp and heatmap_minmax_colormap_top; no dependencies
`timescale 1ns / 1ps

package hmcm_pkg;

    // scaled quotient: 0 .. 1020 in ten divider steps
    localparam int QUO_BITS     = 10;
    localparam int SCALE_BITS   = 11;
    localparam int COLOR_BITS   = 8;
    localparam int USER_BITS    = 2;
    localparam int OUT_BITS     = 3 * COLOR_BITS;
    localparam int STEP_CNT_BITS = 4;

    // tuser bit positions on the slave side
    localparam int USER_ACTION_BIT = 0;
    localparam int USER_FIRST_BIT  = 1;

    localparam logic [SCALE_BITS-1:0] SEG_STEP   = 11'd255;
    localparam logic [SCALE_BITS-1:0] SEG_TWO    = 11'd510;
    localparam logic [SCALE_BITS-1:0] SEG_THREE  = 11'd765;
    localparam logic [SCALE_BITS-1:0] SCALE_FULL = 11'd1020;
    localparam logic [COLOR_BITS-1:0] COLOR_MAX  = 8'd255;

    localparam logic ACTION_SCAN = 1'b0;
    localparam logic ACTION_MAP  = 1'b1;

    typedef struct packed {
        logic accept;   // word taken on the slave side
        logic load;     // set up operands for the divider
        logic step;     // one restoring division step
        logic finish;   // build the pixel into the output register
    } cmd_t;

    typedef struct packed {
        logic in_is_map;  // offered word is a map item
    } status_t;

endpackage

// ===== sv/hmcm_ctrl.sv =====
// hmcm_ctrl: sequencer for the heat-map colormap block
// depends on hmcm_pkg (cmd_t, status_t, step count constants)
`timescale 1ns / 1ps

module hmcm_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    input  hmcm_pkg::status_t status,
    output hmcm_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_FIN  = 4'b1000
    } state_t;

    localparam logic [hmcm_pkg::STEP_CNT_BITS-1:0] LAST_STEP =
        hmcm_pkg::STEP_CNT_BITS'(hmcm_pkg::QUO_BITS - 1);

    state_t state_reg, state_next;
    logic [hmcm_pkg::STEP_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic out_valid_reg, out_valid_next;

    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        out_valid_next = out_valid_reg & ~m_tready;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    if (status.in_is_map) begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD: begin
                cmd.load   = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                // wait for the output slot to free up
                if (!out_valid_reg || m_tready) begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

endmodule

// ===== sv/hmcm_dp.sv =====
// hmcm_dp: datapath of the heat-map colormap block
// frame min/max, scaling, radix-2 restoring divider and color segments; uses hmcm_pkg
`timescale 1ns / 1ps

module hmcm_dp #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8,
    parameter int DATA_BITS     = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  hmcm_pkg::cmd_t                     cmd,
    output hmcm_pkg::status_t                  status,
    input  logic [DATA_BITS-1:0]               s_tdata,
    input  logic [hmcm_pkg::USER_BITS-1:0]     s_tuser,
    output logic [hmcm_pkg::OUT_BITS-1:0]      m_tdata
);

    // range width: holds max - min and the one-point-zero substitute
    localparam int RW = (SAMPLE_BITS > FRACTION_BITS) ? SAMPLE_BITS : FRACTION_BITS + 1;
    localparam int EW = RW + 2;
    localparam int NW = RW + hmcm_pkg::QUO_BITS;
    localparam int QB = hmcm_pkg::QUO_BITS;
    localparam int SW = hmcm_pkg::SCALE_BITS;
    localparam int CW = hmcm_pkg::COLOR_BITS;

    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          in_first;

    logic signed [SAMPLE_BITS-1:0] min_reg, min_next;
    logic signed [SAMPLE_BITS-1:0] max_reg, max_next;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    logic [RW-1:0] range_reg;
    logic [RW-1:0] rem_reg, rem_next;
    logic [QB-1:0] quo_reg, quo_next;
    logic          sat_low_reg, sat_high_reg;
    logic [hmcm_pkg::OUT_BITS-1:0] out_reg;

    logic signed [EW-1:0] min_e, max_e, smp_e, range_e, diff_e;
    logic [RW-1:0]        range_val;
    logic                 sat_low, sat_high;
    logic [RW-1:0]        d_val;
    logic [NW-1:0]        scaled;

    logic [RW:0]   shifted;
    logic [RW+1:0] trial;
    logic          ge;

    logic [SW-1:0] q_full;
    logic          rem_nz;
    logic [SW-1:0] fall_two, rise_two, fall_four;
    logic [CW-1:0] red_c, green_c, blue_c;

    assign in_sample = $signed(s_tdata[SAMPLE_BITS-1:0]);
    assign in_first  = s_tuser[hmcm_pkg::USER_FIRST_BIT];
    assign status.in_is_map = (s_tuser[hmcm_pkg::USER_ACTION_BIT] == hmcm_pkg::ACTION_MAP);

    // running min/max of the frame
    always_comb begin
        min_next = min_reg;
        max_next = max_reg;
        if (cmd.accept && !status.in_is_map) begin
            if (in_first) begin
                min_next = in_sample;
                max_next = in_sample;
            end else begin
                if (in_sample < min_reg) begin
                    min_next = in_sample;
                end
                if (in_sample > max_reg) begin
                    max_next = in_sample;
                end
            end
        end
    end

    // operand setup
    always_comb begin
        min_e     = EW'(min_reg);
        max_e     = EW'(max_reg);
        smp_e     = EW'(sample_reg);
        range_e   = max_e - min_e;
        range_val = (range_e == '0) ? (RW'(1) << FRACTION_BITS) : range_e[RW-1:0];
        diff_e    = smp_e - min_e;
        sat_low   = (diff_e <= $signed(EW'(0)));
        sat_high  = !sat_low && (diff_e >= $signed({2'b00, range_val}));
        d_val     = diff_e[RW-1:0];
        // d * 1020 = d * 1024 - d * 4
        scaled    = (NW'(d_val) << QB) - (NW'(d_val) << 2);
    end

    // one restoring step, quotient bits shift in behind the dividend bits
    always_comb begin
        shifted  = {rem_reg, quo_reg[QB-1]};
        trial    = {1'b0, shifted} - {2'b00, range_reg};
        ge       = ~trial[RW+1];
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (cmd.load) begin
            rem_next = scaled[NW-1:QB];
            quo_next = scaled[QB-1:0];
        end else if (cmd.step) begin
            rem_next = ge ? trial[RW-1:0] : shifted[RW-1:0];
            quo_next = {quo_reg[QB-2:0], ge};
        end
    end

    // four color segments from quotient and remainder
    always_comb begin
        if (sat_low_reg) begin
            q_full = '0;
            rem_nz = 1'b0;
        end else if (sat_high_reg) begin
            q_full = hmcm_pkg::SCALE_FULL;
            rem_nz = 1'b0;
        end else begin
            q_full = SW'(quo_reg);
            rem_nz = (rem_reg != '0);
        end
        fall_two  = hmcm_pkg::SEG_TWO - q_full - SW'(rem_nz);
        rise_two  = q_full - hmcm_pkg::SEG_TWO;
        fall_four = hmcm_pkg::SCALE_FULL - q_full - SW'(rem_nz);
        if (q_full < hmcm_pkg::SEG_STEP) begin
            red_c   = '0;
            green_c = q_full[CW-1:0];
            blue_c  = hmcm_pkg::COLOR_MAX;
        end else if (q_full < hmcm_pkg::SEG_TWO) begin
            red_c   = '0;
            green_c = hmcm_pkg::COLOR_MAX;
            blue_c  = fall_two[CW-1:0];
        end else if (q_full < hmcm_pkg::SEG_THREE) begin
            red_c   = rise_two[CW-1:0];
            green_c = hmcm_pkg::COLOR_MAX;
            blue_c  = '0;
        end else begin
            red_c   = hmcm_pkg::COLOR_MAX;
            green_c = fall_four[CW-1:0];
            blue_c  = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= '0;
            max_reg <= '0;
        end else begin
            min_reg <= min_next;
            max_reg <= max_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sample_reg <= in_sample;
        end
        if (cmd.load) begin
            range_reg    <= range_val;
            sat_low_reg  <= sat_low;
            sat_high_reg <= sat_high;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (cmd.finish) begin
            out_reg <= {blue_c, green_c, red_c};
        end
    end

    assign m_tdata = out_reg;

endmodule

// ===== sv/heatmap_minmax_colormap_top.sv =====
// heat-map colormap top: min/max tracking of a frame and jet color mapping
// scan word: accepted while idle, updates min/max, no output; map word: accept, operand
// setup, ten radix-2 divider steps, then color build into the output register, which
// waits for the output slot to free up; the ten-step divider loop sets the rate
// one word at a time; the output register lets a new word in while a pixel waits
// reset (aresetn low, synchronous): min and max cleared to zero, no pixel pending
`timescale 1ns / 1ps

module heatmap_minmax_colormap_top #(
    parameter int SAMPLE_BITS   = 16,
    parameter int FRACTION_BITS = 8
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]   s_tdata,  // sample
    input  logic [hmcm_pkg::USER_BITS-1:0]     s_tuser,  // action, first_of_frame
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [hmcm_pkg::OUT_BITS-1:0]      m_tdata   // red, green, blue
);

    localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

    hmcm_pkg::cmd_t    cmd;
    hmcm_pkg::status_t status;

    hmcm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    hmcm_dp #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .DATA_BITS     (DATA_BITS)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .status  (status),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tdata (m_tdata)
    );

endmodule

// ===== sim/testbench.sv =====
// testbench for heatmap_minmax_colormap_top: drives scan/map words, predicts each pixel
// from its own min/max tracking and checks the pixel stream in order
// depends on hmcm_pkg and heatmap_minmax_colormap_top
`timescale 1ns / 1ps

module testbench;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_W     = 8;
    localparam int RAND_WORDS = 1750;

    typedef struct {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       first;
        bit                         drain_before;  // hold until all pixels are out
    } word_t;

    typedef struct {
        logic [hmcm_pkg::COLOR_BITS-1:0] red;
        logic [hmcm_pkg::COLOR_BITS-1:0] green;
        logic [hmcm_pkg::COLOR_BITS-1:0] blue;
    } pixel_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [SAMPLE_W-1:0]            s_tdata = '0;
    logic [hmcm_pkg::USER_BITS-1:0] s_tuser = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [hmcm_pkg::OUT_BITS-1:0]  m_tdata;

    word_t  word_q[$];
    pixel_t pixel_q[$];

    logic signed [SAMPLE_W-1:0] frame_lo;
    logic signed [SAMPLE_W-1:0] frame_hi;

    int words_sent = 0;
    int errors = 0;
    int hold_left = 0;
    bit hold_done = 0;

    heatmap_minmax_colormap_top #(
        .SAMPLE_BITS  (SAMPLE_W),
        .FRACTION_BITS(FRAC_W)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // jet color of one sample against the kept min/max, floor of the exact ratio
    function automatic pixel_t jet_pixel(logic signed [SAMPLE_W-1:0] s,
                                         logic signed [SAMPLE_W-1:0] lo,
                                         logic signed [SAMPLE_W-1:0] hi);
        longint rng, x, seg, full;
        pixel_t p;
        rng = longint'(hi) - longint'(lo);
        if (rng <= 0) rng = longint'(1) << FRAC_W;
        seg  = longint'(hmcm_pkg::SEG_STEP) * rng;
        full = longint'(hmcm_pkg::SCALE_FULL) * rng;
        x = (longint'(s) - longint'(lo)) * longint'(hmcm_pkg::SCALE_FULL);
        if (x < 0) x = 0;
        if (x > full) x = full;
        if (x < seg) begin
            p.red = '0;
            p.green = hmcm_pkg::COLOR_BITS'(x / rng);
            p.blue = hmcm_pkg::COLOR_MAX;
        end else if (x < 2 * seg) begin
            p.red = '0;
            p.green = hmcm_pkg::COLOR_MAX;
            p.blue = hmcm_pkg::COLOR_BITS'((2 * seg - x) / rng);
        end else if (x < 3 * seg) begin
            p.red = hmcm_pkg::COLOR_BITS'((x - 2 * seg) / rng);
            p.green = hmcm_pkg::COLOR_MAX;
            p.blue = '0;
        end else begin
            p.red = hmcm_pkg::COLOR_MAX;
            p.green = hmcm_pkg::COLOR_BITS'((full - x) / rng);
            p.blue = '0;
        end
        return p;
    endfunction

    function automatic bit idle_now();
        // no idling at all through a window in the middle of the run
        if (words_sent >= 900 && words_sent < 1150) return 1'b0;
        return $urandom_range(0, 99) < 12;
    endfunction

    // sender: offers the head of word_q, tracks min/max and predicts at acceptance
    always @(posedge aclk) begin : drive
        word_t w;
        logic  offer;
        logic [hmcm_pkg::USER_BITS-1:0] user;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            frame_lo = '0;
            frame_hi = '0;
        end else begin
            offer = s_tvalid;
            if (s_tvalid && s_tready) begin
                w = word_q.pop_front();
                words_sent++;
                if (w.action == hmcm_pkg::ACTION_SCAN) begin
                    if (w.first) begin
                        frame_lo = w.sample;
                        frame_hi = w.sample;
                    end else begin
                        if (w.sample < frame_lo) frame_lo = w.sample;
                        if (w.sample > frame_hi) frame_hi = w.sample;
                    end
                end else begin
                    pixel_q.push_back(jet_pixel(w.sample, frame_lo, frame_hi));
                end
                offer = 1'b0;
            end
            if (!offer && word_q.size() != 0) begin
                if (!(word_q[0].drain_before && pixel_q.size() != 0) && !idle_now()) begin
                    offer = 1'b1;
                    word_q[0].drain_before = 0;
                end
            end
            if (offer) begin
                user = '0;
                user[hmcm_pkg::USER_ACTION_BIT] = word_q[0].action;
                user[hmcm_pkg::USER_FIRST_BIT]  = word_q[0].first;
                s_tdata <= word_q[0].sample;
                s_tuser <= user;
            end
            s_tvalid <= offer;
        end
    end

    // long receiver hold-off once the run is under way, so the block backs up
    always @(posedge aclk) begin : holdoff
        if (!aresetn) begin
            hold_left <= 0;
        end else if (!hold_done && words_sent >= 300) begin
            hold_left <= 400;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // receiver: checks each pixel word against the oldest prediction
    always @(posedge aclk) begin : monitor
        pixel_t want;
        pixel_t got;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.red   = m_tdata[hmcm_pkg::COLOR_BITS-1:0];
                got.green = m_tdata[2*hmcm_pkg::COLOR_BITS-1:hmcm_pkg::COLOR_BITS];
                got.blue  = m_tdata[3*hmcm_pkg::COLOR_BITS-1:2*hmcm_pkg::COLOR_BITS];
                if (pixel_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected pixel r=%0d g=%0d b=%0d",
                                 got.red, got.green, got.blue);
                end else begin
                    want = pixel_q.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        errors++;
                        if (errors <= 10)
                            $display("mismatch: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
            m_tready <= (hold_left == 0) && !idle_now();
        end
    end

    task automatic add_word(logic action, logic signed [SAMPLE_W-1:0] sample, logic first);
        word_t w;
        w.action = action;
        w.sample = sample;
        w.first = first;
        w.drain_before = 0;
        word_q.push_back(w);
    endtask

    initial begin : stimulus
        logic signed [SAMPLE_W-1:0] center;
        int span, nscan, nmap, k, off;
        bit paused;

        // map before any scan: reset min/max, range taken as one
        add_word(hmcm_pkg::ACTION_MAP, 16'sd0, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd128, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, -16'sd32768, 1'b1);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd32767, 1'b0);
        // widest frame
        add_word(hmcm_pkg::ACTION_SCAN, -16'sd32768, 1'b1);
        add_word(hmcm_pkg::ACTION_SCAN, 16'sd32767, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, -16'sd32768, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd32767, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, -16'sd1, 1'b1);
        // segment edges: range of 1020
        add_word(hmcm_pkg::ACTION_SCAN, 16'sd0, 1'b1);
        add_word(hmcm_pkg::ACTION_SCAN, 16'sd1020, 1'b0);
        add_word(hmcm_pkg::ACTION_SCAN, 16'sd500, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd254, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd255, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd509, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd510, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd764, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd765, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd1020, 1'b0);
        // samples beyond the kept ends
        add_word(hmcm_pkg::ACTION_MAP, -16'sd5, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd2000, 1'b0);
        // zero range in a frame
        add_word(hmcm_pkg::ACTION_SCAN, 16'sd100, 1'b1);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd100, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd227, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd356, 1'b0);
        add_word(hmcm_pkg::ACTION_MAP, 16'sd50, 1'b0);

        paused = 0;
        while (word_q.size() < RAND_WORDS) begin
            if (!paused && word_q.size() > 1100) begin
                // sender waits here until every pixel has drained
                add_word(hmcm_pkg::ACTION_SCAN, SAMPLE_W'($urandom), 1'b1);
                word_q[word_q.size() - 1].drain_before = 1;
                paused = 1;
            end
            center = SAMPLE_W'($urandom);
            case ($urandom_range(0, 2))
                0:       span = $urandom_range(0, 4);
                1:       span = $urandom_range(1, 400);
                default: span = $urandom_range(1, 65535);
            endcase
            nscan = $urandom_range(1, 8);
            for (k = 0; k < nscan; k++) begin
                off = int'($urandom_range(0, 2 * span)) - span;
                add_word(hmcm_pkg::ACTION_SCAN, SAMPLE_W'(center + off), k == 0);
            end
            nmap = $urandom_range(1, 8);
            for (k = 0; k < nmap; k++) begin
                off = int'($urandom_range(0, 3 * span)) - (3 * span) / 2;
                add_word(hmcm_pkg::ACTION_MAP, SAMPLE_W'(center + off),
                         1'($urandom_range(0, 1)));
            end
            // noise: stray scans and maps of any value
            if ($urandom_range(0, 9) == 0)
                add_word(1'($urandom_range(0, 1)), SAMPLE_W'($urandom),
                         1'($urandom_range(0, 1)));
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (word_q.size() != 0) @(posedge aclk);
        while (pixel_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
        if (errors == 0 && pixel_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #1000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== heatmap_minmax_colormap_top.f =====
sv/hmcm_pkg.sv
sv/hmcm_ctrl.sv
sv/hmcm_dp.sv
sv/heatmap_minmax_colormap_top.sv
sim/testbench.sv
